// ===== hw/rtl/fctpe_pkg.sv =====
// ----------------------------------------------------------------------------
// fctpe_pkg
// Shared types and constants for the four channel trigger pulse engine:
// transfer payloads, action codes, register indexes and lane status.
// ----------------------------------------------------------------------------
`default_nettype none

package fctpe_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int LEVEL_W      = 16;
	localparam int TIME_W       = 64;
	localparam int PWIDTH_W     = 32;
	localparam int LAT_W        = 32;
	localparam int CFG_IDX_W    = 3;

	localparam logic signed [LEVEL_W-1:0] HIGH_RESET = 16'sd5000;
	localparam logic signed [LEVEL_W-1:0] LOW_RESET  = 16'sd0;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL_0  = 3'd4;

	typedef enum logic [1:0] {
		ACT_FIRE  = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [3:0]          channel_mask;
		logic [TIME_W-1:0]   start_time_0;
		logic [TIME_W-1:0]   start_time_1;
		logic [TIME_W-1:0]   start_time_2;
		logic [TIME_W-1:0]   start_time_3;
		logic [PWIDTH_W-1:0] width_0;
		logic [PWIDTH_W-1:0] width_1;
		logic [PWIDTH_W-1:0] width_2;
		logic [PWIDTH_W-1:0] width_3;
		logic [TIME_W-1:0]   now_time;
	} cmd_item_t;

	typedef struct packed {
		logic                      drive_update;
		logic signed [LEVEL_W-1:0] out_level_0;
		logic signed [LEVEL_W-1:0] out_level_1;
		logic signed [LEVEL_W-1:0] out_level_2;
		logic signed [LEVEL_W-1:0] out_level_3;
		logic [3:0]                active_channels;
		logic [LAT_W-1:0]          worst_latency;
	} rsp_item_t;

	// control from the pipeline to lanes and merge
	typedef struct packed {
		logic       commit;
		logic [1:0] action;
	} lane_ctl_t;

	// what one lane found for the item in stage 1
	typedef struct packed {
		logic             arm;
		logic             expire;
		logic [LAT_W-1:0] lat;
	} lane_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fctpe_lane.sv =====
// ----------------------------------------------------------------------------
// fctpe_lane
// One trigger channel: keeps its end time, works out its saturated fire
// latency as the item is taken and checks expiry against the tick time.
// ----------------------------------------------------------------------------
`default_nettype none

module fctpe_lane (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  wire logic [fctpe_pkg::TIME_W-1:0]       start_in,
	input  wire logic [fctpe_pkg::TIME_W-1:0]       now_in,
	input  wire fctpe_pkg::lane_ctl_t               ctl,
	input  wire logic                               sel_s1,
	input  wire logic [fctpe_pkg::TIME_W-1:0]       start_s1,
	input  wire logic [fctpe_pkg::PWIDTH_W-1:0]     width_s1,
	input  wire logic [fctpe_pkg::TIME_W-1:0]       now_s1,
	input  wire logic                               active,
	output fctpe_pkg::lane_stat_t                   stat
);

	logic [fctpe_pkg::TIME_W-1:0] end_q;
	logic [fctpe_pkg::LAT_W-1:0]  lat_s1;
	logic [fctpe_pkg::TIME_W-1:0] diff;
	logic                         is_fire;
	logic                         is_tick;
	logic                         is_clear;

	// latency floored at zero and saturated to 32 bits
	always_comb begin
		diff = (now_in > start_in) ? (now_in - start_in) : '0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lat_s1 <= (|diff[fctpe_pkg::TIME_W-1:fctpe_pkg::LAT_W]) ? '1
				: diff[fctpe_pkg::LAT_W-1:0];
		end
	end

	assign is_fire  = (ctl.action == fctpe_pkg::ACT_FIRE);
	assign is_tick  = (ctl.action == fctpe_pkg::ACT_TICK);
	assign is_clear = (ctl.action == fctpe_pkg::ACT_CLEAR);

	always_comb begin
		stat.arm    = is_fire && sel_s1 && (width_s1 != '0);
		stat.expire = (now_s1 >= end_q);
		stat.lat    = lat_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= '0;
		end else if (ctl.commit) begin
			if (stat.arm) begin
				end_q <= start_s1 + {{(fctpe_pkg::TIME_W-fctpe_pkg::PWIDTH_W){1'b0}}, width_s1};
			end else if ((is_tick && active && stat.expire) || is_clear) begin
				end_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fctpe_merge.sv =====
// ----------------------------------------------------------------------------
// fctpe_merge
// Combines the lane results: active mask, last driven mask, latency peak,
// level registers and the result item for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fctpe_merge #(
	parameter int CHANNELS = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire fctpe_pkg::lane_ctl_t                 ctl,
	input  wire fctpe_pkg::lane_stat_t                stat [CHANNELS],
	input  wire logic                                 cfg_we,
	input  wire logic [fctpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fctpe_pkg::LEVEL_W-1:0]        cfg_data,
	output logic [CHANNELS-1:0]                       active,
	output fctpe_pkg::rsp_item_t                      result
);

	logic signed [fctpe_pkg::LEVEL_W-1:0] high_q [CHANNELS];
	logic signed [fctpe_pkg::LEVEL_W-1:0] low_q  [CHANNELS];
	logic [3:0]                           active_q;
	logic [3:0]                           last_q;
	logic                                 last_vld_q;
	logic [fctpe_pkg::LAT_W-1:0]          peak_q;

	logic [3:0]                           arm_m;
	logic [3:0]                           exp_m;
	logic [3:0]                           act_n;
	logic                                 change;
	logic                                 drive;
	logic [fctpe_pkg::LAT_W-1:0]          pk;
	logic signed [fctpe_pkg::LEVEL_W-1:0] lv [4];

	always_comb begin
		arm_m = '0;
		exp_m = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			arm_m[i] = stat[i].arm;
			exp_m[i] = stat[i].expire && active_q[i];
		end
		act_n  = active_q;
		change = 1'b0;
		drive  = 1'b0;
		pk     = peak_q;
		case (ctl.action)
			fctpe_pkg::ACT_FIRE: begin
				if (arm_m != '0) begin
					act_n  = active_q | arm_m;
					change = 1'b1;
				end
				for (int i = 0; i < CHANNELS; i++) begin
					if (stat[i].arm && (stat[i].lat > pk)) begin
						pk = stat[i].lat;
					end
				end
			end
			fctpe_pkg::ACT_TICK: begin
				if (exp_m != '0) begin
					act_n  = active_q & ~exp_m;
					change = 1'b1;
				end
			end
			fctpe_pkg::ACT_CLEAR: begin
				act_n = '0;
				drive = 1'b1;
			end
			default: ;
		endcase
		if (change && !(last_vld_q && (last_q == act_n))) begin
			drive = 1'b1;
		end
		for (int i = 0; i < 4; i++) begin
			lv[i] = '0;
		end
		for (int i = 0; i < CHANNELS; i++) begin
			if (drive) begin
				lv[i] = act_n[i] ? high_q[i] : low_q[i];
			end
		end
	end

	always_comb begin
		result.drive_update    = drive;
		result.out_level_0     = lv[0];
		result.out_level_1     = lv[1];
		result.out_level_2     = lv[2];
		result.out_level_3     = lv[3];
		result.active_channels = act_n;
		result.worst_latency   = pk;
	end

	assign active = active_q[CHANNELS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				high_q[i] <= fctpe_pkg::HIGH_RESET;
				low_q[i]  <= fctpe_pkg::LOW_RESET;
			end
			active_q   <= '0;
			last_q     <= '0;
			last_vld_q <= 1'b0;
			peak_q     <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (cfg_index == (fctpe_pkg::REG_HIGH_LEVEL_0
					+ fctpe_pkg::CFG_IDX_W'(i))) begin
					high_q[i] <= cfg_data;
				end
				if (cfg_index == (fctpe_pkg::REG_LOW_LEVEL_0
					+ fctpe_pkg::CFG_IDX_W'(i))) begin
					low_q[i] <= cfg_data;
				end
			end
			// any level write forgets what was last driven
			last_vld_q <= 1'b0;
		end else if (ctl.commit) begin
			active_q <= act_n;
			peak_q   <= pk;
			if (drive) begin
				last_q     <= act_n;
				last_vld_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/four_channel_trigger_pulse_engine.sv =====
// ----------------------------------------------------------------------------
// four_channel_trigger_pulse_engine
// One-shot trigger pulses on up to four channels with programmable levels.
//
// Usage: a command transfer on cmd (cmd_valid / cmd_stall) carries a fire,
// tick or clear-all item; every command gives exactly one response transfer
// on rsp (rsp_valid / rsp_stall). Levels are written on cfg_we / cfg_index /
// cfg_data while the engine is idle.
// Path: a command passes through the stage 1 register and then the output
// register before rsp_valid rises for its response.
// Throughput: one command per cycle while not stalled; the lanes compare and
// add in parallel and the active mask loop closes in the single merge stage.
// Reset: all channels idle, end times zero, high levels 5000, low levels 0,
// latency peak zero, nothing marked as driven.
// Stall: the output register holds its response; stage 1 still takes one
// more command, after which cmd_stall rises until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_trigger_pulse_engine #(
	parameter int CHANNELS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire fctpe_pkg::cmd_item_t              cmd,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output fctpe_pkg::rsp_item_t                   rsp,
	input  wire logic                              cfg_we,
	input  wire logic [fctpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fctpe_pkg::LEVEL_W-1:0]     cfg_data
);

	logic                          s1_vld_q;
	fctpe_pkg::cmd_item_t          item_s1;
	logic                          out_vld_q;
	fctpe_pkg::rsp_item_t          rsp_q;
	logic                          accept;
	logic                          commit;
	fctpe_pkg::lane_ctl_t          ctl;
	fctpe_pkg::lane_stat_t         stat [CHANNELS];
	fctpe_pkg::rsp_item_t          result;
	logic [CHANNELS-1:0]           active;

	logic [fctpe_pkg::TIME_W-1:0]   start_in [fctpe_pkg::MAX_CHANNELS];
	logic [fctpe_pkg::TIME_W-1:0]   start_s1 [fctpe_pkg::MAX_CHANNELS];
	logic [fctpe_pkg::PWIDTH_W-1:0] width_s1 [fctpe_pkg::MAX_CHANNELS];

	assign commit    = s1_vld_q && (!out_vld_q || !rsp_stall);
	assign cmd_stall = s1_vld_q && !commit;
	assign accept    = cmd_valid && !cmd_stall;

	assign ctl.commit = commit;
	assign ctl.action = item_s1.action;

	always_comb begin
		start_in[0] = cmd.start_time_0;
		start_in[1] = cmd.start_time_1;
		start_in[2] = cmd.start_time_2;
		start_in[3] = cmd.start_time_3;
		start_s1[0] = item_s1.start_time_0;
		start_s1[1] = item_s1.start_time_1;
		start_s1[2] = item_s1.start_time_2;
		start_s1[3] = item_s1.start_time_3;
		width_s1[0] = item_s1.width_0;
		width_s1[1] = item_s1.width_1;
		width_s1[2] = item_s1.width_2;
		width_s1[3] = item_s1.width_3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (commit) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		fctpe_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (accept),
			.start_in (start_in[g]),
			.now_in   (cmd.now_time),
			.ctl      (ctl),
			.sel_s1   (item_s1.channel_mask[g]),
			.start_s1 (start_s1[g]),
			.width_s1 (width_s1[g]),
			.now_s1   (item_s1.now_time),
			.active   (active[g]),
			.stat     (stat[g])
		);
	end

	fctpe_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.active    (active),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== dv/four_channel_trigger_pulse_engine_tb.sv =====
// ----------------------------------------------------------------------------
// four_channel_trigger_pulse_engine_tb
// Drives fire, tick and clear commands into the pulse engine with random gaps
// and response stalls, predicts every response from a cycle-free model of the
// channel timers, drive levels and latency peak, and compares each response
// field by field. Levels are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_trigger_pulse_engine_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import fctpe_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int PIPE_DEPTH = 2;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 160;

	typedef enum {LV_RANDOM, LV_HI_MAX, LV_HI_MIN} level_plan_t;

	class pulse_scoreboard;
		localparam logic [7:0] NOTHING_DRIVEN = 8'hFF;

		logic signed [LEVEL_W-1:0] high_mv[MAX_CHANNELS];
		logic signed [LEVEL_W-1:0] low_mv[MAX_CHANNELS];
		logic [TIME_W-1:0]         end_us[MAX_CHANNELS];
		logic [3:0]                armed;
		logic [7:0]                shown_mask;
		logic [LAT_W-1:0]          peak_lat;
		rsp_item_t                 pending_rsp[$];
		int                        errors;

		function new();
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				high_mv[i] = HIGH_RESET;
				low_mv[i] = LOW_RESET;
				end_us[i] = '0;
			end
			armed = '0;
			shown_mask = NOTHING_DRIVEN;
			peak_lat = '0;
			errors = 0;
		endfunction

		function void write_level(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
			if (idx < REG_LOW_LEVEL_0)
				high_mv[idx - REG_HIGH_LEVEL_0] = val;
			else
				low_mv[idx - REG_LOW_LEVEL_0] = val;
			shown_mask = NOTHING_DRIVEN;
		endfunction

		function void note_cmd(cmd_item_t c);
			logic [TIME_W-1:0]   st[MAX_CHANNELS];
			logic [PWIDTH_W-1:0] wd[MAX_CHANNELS];
			logic [TIME_W-1:0]   lat;
			logic [3:0]          sel;
			logic [3:0]          nxt;
			bit                  want_drive;
			bit                  forced;
			rsp_item_t           r;
			st = '{c.start_time_0, c.start_time_1, c.start_time_2, c.start_time_3};
			wd = '{c.width_0, c.width_1, c.width_2, c.width_3};
			want_drive = 1'b0;
			forced = 1'b0;
			r = '0;
			case (c.action)
			ACT_FIRE: begin
				sel = c.channel_mask;
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					if (sel[i]) begin
						if (wd[i] == '0) begin
							sel[i] = 1'b0;
						end else begin
							lat = (c.now_time > st[i]) ? c.now_time - st[i] : '0;
							end_us[i] = st[i] + {{(TIME_W - PWIDTH_W){1'b0}}, wd[i]};
							if (lat > {{(TIME_W - LAT_W){1'b0}}, peak_lat})
								peak_lat = (lat > 64'hFFFF_FFFF) ? '1 : lat[LAT_W-1:0];
						end
					end
				end
				if (sel != '0) begin
					armed = armed | sel;
					want_drive = 1'b1;
				end
			end
			ACT_TICK: begin
				if (armed != '0) begin
					nxt = armed;
					for (int i = 0; i < MAX_CHANNELS; i++) begin
						if (nxt[i] && c.now_time >= end_us[i]) begin
							nxt[i] = 1'b0;
							end_us[i] = '0;
						end
					end
					if (nxt != armed) begin
						armed = nxt;
						want_drive = 1'b1;
					end
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < MAX_CHANNELS; i++)
					end_us[i] = '0;
				armed = '0;
				want_drive = 1'b1;
				forced = 1'b1;
			end
			default: ;
			endcase
			// clear always drives, otherwise only on a change of the driven mask
			if (want_drive && (forced || {4'b0, armed} != shown_mask)) begin
				r.drive_update = 1'b1;
				r.out_level_0 = armed[0] ? high_mv[0] : low_mv[0];
				r.out_level_1 = armed[1] ? high_mv[1] : low_mv[1];
				r.out_level_2 = armed[2] ? high_mv[2] : low_mv[2];
				r.out_level_3 = armed[3] ? high_mv[3] : low_mv[3];
				shown_mask = {4'b0, armed};
			end
			r.active_channels = armed;
			r.worst_latency = peak_lat;
			pending_rsp.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task field_check(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", field, got, want));
		endtask

		task check_rsp(rsp_item_t got);
			rsp_item_t want;
			if (pending_rsp.size() == 0) begin
				report("response with no command outstanding");
				return;
			end
			want = pending_rsp.pop_front();
			field_check("drive_update", got.drive_update, want.drive_update);
			field_check("out_level_0", got.out_level_0, want.out_level_0);
			field_check("out_level_1", got.out_level_1, want.out_level_1);
			field_check("out_level_2", got.out_level_2, want.out_level_2);
			field_check("out_level_3", got.out_level_3, want.out_level_3);
			field_check("active_channels", got.active_channels, want.active_channels);
			field_check("worst_latency", got.worst_latency, want.worst_latency);
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_item_t            cmd;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_item_t            rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEVEL_W-1:0]   cfg_data;

	logic [TIME_W-1:0] wall_us;
	bit                calm;
	pulse_scoreboard   sb = new();

	four_channel_trigger_pulse_engine #(.CHANNELS(MAX_CHANNELS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(5_000_000);
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(rsp);
	end

	// receiver back-pressure in bursts, with long quiet stretches in between
	initial begin
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (calm) begin
				@(posedge clk);
			end else begin
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				    : $urandom_range(1, 16)) @(posedge clk);
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic cmd_item_t fire_cmd(logic [3:0] mask, logic [TIME_W-1:0] st,
	    logic [PWIDTH_W-1:0] wd, logic [TIME_W-1:0] now);
		cmd_item_t c;
		c = '0;
		c.action = ACT_FIRE;
		c.channel_mask = mask;
		c.start_time_0 = st;
		c.start_time_1 = st;
		c.start_time_2 = st;
		c.start_time_3 = st;
		c.width_0 = wd;
		c.width_1 = wd;
		c.width_2 = wd;
		c.width_3 = wd;
		c.now_time = now;
		return c;
	endfunction

	function automatic cmd_item_t tick_cmd(logic [TIME_W-1:0] now);
		cmd_item_t c;
		c = '0;
		c.action = ACT_TICK;
		c.now_time = now;
		return c;
	endfunction

	function automatic cmd_item_t clear_cmd();
		cmd_item_t c;
		c = '0;
		c.action = ACT_CLEAR;
		return c;
	endfunction

	// mostly coherent timelines around wall_us, plus a share of raw noise
	function automatic cmd_item_t random_cmd(bit late);
		cmd_item_t           c;
		logic [15*32-1:0]    noise;
		logic [TIME_W-1:0]   st[MAX_CHANNELS];
		logic [PWIDTH_W-1:0] wd[MAX_CHANNELS];
		int unsigned         pick;
		int unsigned         how;
		for (int k = 0; k < 15; k++)
			noise[k*32 +: 32] = $urandom;
		c = noise[$bits(cmd_item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// keep the latency peak from saturating before the last phase
			if (c.action == ACT_FIRE && !late)
				c.now_time = '0;
		end else if (pick < 52) begin
			c.action = ACT_FIRE;
			c.channel_mask = 4'($urandom_range(1, 15));
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				how = $urandom_range(0, 99);
				if (how < 6)
					wd[i] = '0;
				else if (how < 10)
					wd[i] = $urandom;
				else
					wd[i] = $urandom_range(1, 300);
				how = $urandom_range(0, 99);
				if (how < 2)
					st[i] = wall_us - (late ? $urandom : $urandom_range(0, 1 << 20));
				else if (how < 12)
					st[i] = wall_us + $urandom_range(1, 200);
				else if (how == 99)
					st[i] = ~64'($urandom_range(0, 100));
				else
					st[i] = wall_us - $urandom_range(0, 40);
			end
			c.start_time_0 = st[0];
			c.start_time_1 = st[1];
			c.start_time_2 = st[2];
			c.start_time_3 = st[3];
			c.width_0 = wd[0];
			c.width_1 = wd[1];
			c.width_2 = wd[2];
			c.width_3 = wd[3];
			c.now_time = wall_us;
			wall_us = wall_us + $urandom_range(0, 3);
		end else if (pick < 88) begin
			c.action = ACT_TICK;
			wall_us = wall_us + $urandom_range(0, 150);
			c.now_time = wall_us;
		end else if (pick < 94) begin
			c.action = ACT_CLEAR;
		end else begin
			c.action = ACT_UNUSED;
		end
		return c;
	endfunction

	task automatic send_cmd(cmd_item_t c);
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_cmd(c);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 6) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic reprogram(logic [7:0] which, level_plan_t plan);
		logic [CFG_IDX_W-1:0] idx;
		logic [LEVEL_W-1:0]   val;
		for (int i = 0; i < 2 * MAX_CHANNELS; i++) begin
			if (which[i]) begin
				if (i < MAX_CHANNELS)
					idx = REG_HIGH_LEVEL_0 + CFG_IDX_W'(i);
				else
					idx = REG_LOW_LEVEL_0 + CFG_IDX_W'(i - MAX_CHANNELS);
				case (plan)
				LV_HI_MAX: val = (i < MAX_CHANNELS) ? 16'h7FFF : 16'h8000;
				LV_HI_MIN: val = (i < MAX_CHANNELS) ? 16'h8000 : 16'h7FFF;
				default:   val = ($urandom_range(0, 3) == 0)
				    ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
				endcase
				cfg_we <= 1'b1;
				cfg_index <= idx;
				cfg_data <= val;
				@(posedge clk);
				sb.write_level(idx, val);
			end
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		cmd_item_t c;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		calm = 1'b0;
		wall_us = 64'd1000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners on reset levels
		send_cmd(tick_cmd(64'd0));
		send_cmd(clear_cmd());
		send_cmd(fire_cmd(4'h0, 64'd10, 32'd5, 64'd10));
		send_cmd(fire_cmd(4'hF, 64'd10, 32'd0, 64'd10));
		send_cmd(fire_cmd(4'h1, 64'd100, 32'd50, 64'd120));
		send_cmd(fire_cmd(4'h1, 64'd100, 32'd60, 64'd100));
		send_cmd(tick_cmd(64'd159));
		send_cmd(tick_cmd(64'd160));
		// end time wraps past 2^64
		send_cmd(fire_cmd(4'hF, 64'hFFFF_FFFF_FFFF_FFF0, '1, 64'd0));
		send_cmd(tick_cmd(64'h0000_0000_FFFF_FFEE));
		send_cmd(tick_cmd(64'h0000_0000_FFFF_FFEF));
		c = random_cmd(1'b0);
		c.action = ACT_UNUSED;
		send_cmd(c);
		c = fire_cmd(4'h3, 64'd5, 32'd7, 64'd5);
		c.width_0 = '0;
		send_cmd(c);
		send_cmd(clear_cmd());
		send_cmd(clear_cmd());
		drain();
		reprogram(8'hFF, LV_HI_MAX);
		send_cmd(fire_cmd(4'h5, 64'd200, 32'd10, 64'd200));
		// a level write alone forces the same mask to drive again
		drain();
		reprogram(8'h01, LV_RANDOM);
		send_cmd(fire_cmd(4'h5, 64'd200, 32'd10, 64'd205));
		send_cmd(tick_cmd(64'd210));

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			calm = (phase == PHASES - 1);
			reprogram((phase == 3) ? 8'($urandom_range(1, 255)) : 8'hFF,
			    (phase == 2) ? LV_HI_MIN : LV_RANDOM);
			wall_us = {2'b00, 30'($urandom), 32'($urandom)};
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				maybe_pause();
				if (!calm && $urandom_range(0, 99) == 0)
					drain();
				send_cmd(random_cmd(phase == PHASES - 1));
			end
		end

		// latency at the 32-bit limit, then beyond it
		send_cmd(fire_cmd(4'h1, 64'd0, 32'd1, 64'hFFFF_FFFF));
		send_cmd(fire_cmd(4'h2, 64'd0, 32'd1, '1));
		send_cmd(tick_cmd('1));
		send_cmd(clear_cmd());
		drain();
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/fctpe_pkg.sv
hw/rtl/fctpe_lane.sv
hw/rtl/fctpe_merge.sv
hw/rtl/four_channel_trigger_pulse_engine.sv
dv/four_channel_trigger_pulse_engine_tb.sv
